### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

    localparam int VALUE_BITS_DEF = 31;

    // operation selector codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // result status codes
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // how the back end must treat a queued transaction
    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,  // bad operand, flags cleared
        KIND_DIVZ    = 2'd1,  // divide by zero fraction, flags kept
        KIND_ZERO    = 2'd2,  // zero numerator, result 0/1
        KIND_WORK    = 2'd3   // needs gcd reduction
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg;
        logic  lt;
        logic  eq;
        logic  gt;
    } t_cls;

endpackage

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions, result reduced to lowest terms with a positive denominator,
// plus less/equal/greater flags of a against b.
//
// Input channel (s_axis): tuser = operation, tdata = operands.
// Output channel (m_axis): tuser = status, tdata = reduced result and flags.
// One result transaction per input transaction, in order.
//
// The front end captures the operands, forms the products and classifies,
// the queue is popped, then the back end runs a binary gcd with one shift or
// subtract per cycle on the 2*VALUE_BITS-bit intermediates, then forms the
// two quotients with a bit-serial divider, then loads the output register.
// Bad operands, divide by zero and zero results skip the gcd and divide.
// Worst case is set by the gcd loop and the bit-serial divider.
// A two-entry queue between front and back lets the front take the next
// transaction while the back is busy.
// Reset (synchronous, active low) empties the queue and output register.
// When the receiver stalls the result holds in the output register; the
// back end then waits, the queue fills, and s_axis_tready drops.
module rational_arithmetic_unit #(
    parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] operation
    input  logic [1:0]            s_axis_tuser,
    // a_numerator, a_denominator, b_numerator, b_denominator, zero pad
    input  logic [((4*VALUE_BITS-2+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] status
    output logic [1:0]            m_axis_tuser,
    // result_numerator, result_denominator, is_less, is_equal, is_greater, pad
    output logic [((2*VALUE_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import rau_pkg::*;

    localparam int W      = VALUE_BITS;
    localparam int DW     = 2 * W;
    localparam int OUT_W  = ((2*W+2+7)/8)*8;
    localparam int Q_W    = $bits(t_cls) + 2*DW;

    logic [W-1:0]  w_an, w_bn, w_num;
    logic [W-2:0]  w_ad, w_bd, w_den;
    logic          w_push, w_full, w_pop, w_empty;
    t_cls          w_cls_f, w_cls_b;
    logic [DW-1:0] w_mag_f, w_den_f, w_mag_b, w_den_b;
    logic [Q_W-1:0] w_q_in, w_q_out;
    logic          w_lt, w_eq, w_gt;

    // operand unpack, lowest field first
    assign w_an = s_axis_tdata[W-1:0];
    assign w_ad = s_axis_tdata[2*W-2:W];
    assign w_bn = s_axis_tdata[3*W-2:2*W-1];
    assign w_bd = s_axis_tdata[4*W-3:3*W-1];

    rau_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_an    (w_an),
        .i_ad    (w_ad),
        .i_bn    (w_bn),
        .i_bd    (w_bd),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_cls   (w_cls_f),
        .o_mag   (w_mag_f),
        .o_den   (w_den_f)
    );

    assign w_q_in = {w_cls_f, w_mag_f, w_den_f};
    assign {w_cls_b, w_mag_b, w_den_b} = w_q_out;

    rau_fifo #(.WIDTH(Q_W), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    rau_back #(.W(W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_cls    (w_cls_b),
        .i_mag    (w_mag_b),
        .i_den    (w_den_b),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_status (m_axis_tuser),
        .o_lt     (w_lt),
        .o_eq     (w_eq),
        .o_gt     (w_gt)
    );

    assign m_axis_tdata = OUT_W'({w_gt, w_eq, w_lt, w_den, w_num});
endmodule

### rtl/core/rau_fifo.sv
`timescale 1ns / 1ps
module rau_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

### rtl/core/rau_front.sv
`timescale 1ns / 1ps
module rau_front #(
    parameter int W = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [W-1:0]         i_an,
    input  logic [W-2:0]         i_ad,
    input  logic [W-1:0]         i_bn,
    input  logic [W-2:0]         i_bd,
    output logic                 o_push,
    input  logic                 i_full,
    output rau_pkg::t_cls        o_cls,
    output logic [2*W-1:0]       o_mag,
    output logic [2*W-1:0]       o_den
);
    import rau_pkg::*;

    localparam int DW = 2 * W;
    localparam int M  = W - 1;

    typedef enum logic [1:0] { S_IDLE, S_MUL, S_CMB } t_state;

    t_state         r_state;
    logic [1:0]     r_op;
    logic           r_sa, r_sb, r_bad;
    logic [M-1:0]   r_ma, r_mb, r_ad, r_bd;
    logic [2*M-1:0] r_pl, r_pr, r_pab, r_pd, r_pe;

    logic [W-1:0]          w_an_abs, w_bn_abs;
    logic                  w_bad;
    logic signed [DW-1:0]  w_l, w_r, w_pab, w_num;
    logic [DW-1:0]         w_mag;

    assign o_ready  = (r_state == S_IDLE);
    assign w_an_abs = i_an[W-1] ? W'(-i_an) : i_an;
    assign w_bn_abs = i_bn[W-1] ? W'(-i_bn) : i_bn;
    // most negative code is out of range, zero denominator too
    assign w_bad = (i_an == {1'b1, {(W-1){1'b0}}}) || (i_bn == {1'b1, {(W-1){1'b0}}})
                || (i_ad == '0) || (i_bd == '0);

    // signed cross products
    assign w_l   = r_sa ? -$signed({2'b00, r_pl}) : $signed({2'b00, r_pl});
    assign w_r   = r_sb ? -$signed({2'b00, r_pr}) : $signed({2'b00, r_pr});
    assign w_pab = (r_sa ^ r_sb) ? -$signed({2'b00, r_pab}) : $signed({2'b00, r_pab});

    always_comb begin
        unique case (r_op)
            OP_ADD: w_num = w_l + w_r;
            OP_SUB: w_num = w_l - w_r;
            OP_MUL: w_num = w_pab;
            default: w_num = (r_sa ^ r_sb) ? -$signed({2'b00, r_pl})
                                            : $signed({2'b00, r_pl});
        endcase
    end

    assign w_mag = w_num[DW-1] ? DW'(-w_num) : DW'(w_num);
    assign o_mag = w_mag;
    assign o_den = (r_op == OP_DIV) ? {2'b00, r_pe} : {2'b00, r_pd};

    always_comb begin
        o_cls.neg = w_num[DW-1];
        o_cls.lt  = !r_bad && (w_l < w_r);
        o_cls.eq  = !r_bad && (w_l == w_r);
        o_cls.gt  = !r_bad && (w_l > w_r);
        priority if (r_bad) begin
            o_cls.kind = KIND_INVALID;
        end else if (r_op == OP_DIV && r_mb == '0) begin
            o_cls.kind = KIND_DIVZ;
        end else if (w_mag == '0) begin
            o_cls.kind = KIND_ZERO;
        end else begin
            o_cls.kind = KIND_WORK;
        end
    end

    assign o_push = (r_state == S_CMB) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_MUL;
                        r_op    <= i_op;
                        r_sa    <= i_an[W-1];
                        r_sb    <= i_bn[W-1];
                        r_ma    <= w_an_abs[M-1:0];
                        r_mb    <= w_bn_abs[M-1:0];
                        r_ad    <= i_ad;
                        r_bd    <= i_bd;
                        r_bad   <= w_bad;
                    end
                end
                S_MUL: begin
                    r_pl    <= r_ma * r_bd;
                    r_pr    <= r_mb * r_ad;
                    r_pab   <= r_ma * r_mb;
                    r_pd    <= r_ad * r_bd;
                    r_pe    <= r_ad * r_mb;
                    r_state <= S_CMB;
                end
                S_CMB: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/rau_back.sv
`timescale 1ns / 1ps
module rau_back #(
    parameter int W = 31
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  rau_pkg::t_cls   i_cls,
    input  logic [2*W-1:0]  i_mag,
    input  logic [2*W-1:0]  i_den,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [W-1:0]    o_num,
    output logic [W-2:0]    o_den,
    output logic [1:0]      o_status,
    output logic            o_lt,
    output logic            o_eq,
    output logic            o_gt
);
    import rau_pkg::*;

    localparam int DW = 2 * W;
    localparam int KW = $clog2(DW + 1);

    typedef enum logic [1:0] { S_IDLE, S_GCD, S_DIV, S_OUT } t_state;

    t_state        r_state;
    t_cls          r_cls;
    logic [DW-1:0] r_x, r_y, r_g, r_qa, r_qd, r_ra, r_rd;
    logic [KW-1:0] r_k, r_cnt;
    logic [W-1:0]  r_fin_num;
    logic [W-2:0]  r_fin_den;
    logic [1:0]    r_fin_st;
    logic          r_ov;

    logic [DW-1:0] w_ta, w_td, w_qa, w_qd;
    logic          w_ba, w_bd, w_ovf;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_ov;

    // one restoring-division step on both quotients
    assign w_ta = {r_ra[DW-2:0], r_qa[DW-1]};
    assign w_td = {r_rd[DW-2:0], r_qd[DW-1]};
    assign w_ba = (w_ta >= r_g);
    assign w_bd = (w_td >= r_g);
    assign w_qa = {r_qa[DW-2:0], w_ba};
    assign w_qd = {r_qd[DW-2:0], w_bd};
    assign w_ovf = (w_qa[DW-1:W-1] != '0) || (w_qd[DW-1:W-1] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cls     <= i_cls;
                        r_fin_num <= '0;
                        r_fin_den <= (W-1)'(1);
                        unique case (i_cls.kind)
                            KIND_INVALID, KIND_DIVZ: begin
                                r_fin_st <= ST_INVALID;
                                r_state  <= S_OUT;
                            end
                            KIND_ZERO: begin
                                r_fin_st <= ST_VALID;
                                r_state  <= S_OUT;
                            end
                            default: begin
                                r_x     <= i_mag;
                                r_y     <= i_den;
                                r_qa    <= i_mag;
                                r_qd    <= i_den;
                                r_k     <= '0;
                                r_state <= S_GCD;
                            end
                        endcase
                    end
                end
                S_GCD: begin
                    // binary gcd, one shift or subtract per cycle
                    priority if (r_x == r_y) begin
                        r_g     <= r_x << r_k;
                        r_ra    <= '0;
                        r_rd    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x > r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
                S_DIV: begin
                    r_qa  <= w_qa;
                    r_qd  <= w_qd;
                    r_ra  <= w_ba ? w_ta - r_g : w_ta;
                    r_rd  <= w_bd ? w_td - r_g : w_td;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == KW'(DW - 1)) begin
                        r_state <= S_OUT;
                        if (w_ovf) begin
                            r_fin_st <= ST_OVERFLOW;
                        end else begin
                            r_fin_st  <= ST_VALID;
                            r_fin_num <= r_cls.neg ? W'(-w_qa[W-1:0]) : w_qa[W-1:0];
                            r_fin_den <= w_qd[W-2:0];
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        o_num    <= r_fin_num;
                        o_den    <= r_fin_den;
                        o_status <= r_fin_st;
                        o_lt     <= r_cls.lt;
                        o_eq     <= r_cls.eq;
                        o_gt     <= r_cls.gt;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GCD |-> (r_x != '0) && (r_y != '0))
        else $error("gcd operand reached zero");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_g != '0)
        else $error("zero divisor in reduction");

    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_fin_den != '0)
        else $error("zero result denominator");
endmodule
